// File: sv/stjp_pkg.sv
// ----------------------------------------------------------------------------
// Synchronized trapezoid planner package
// Shared types, constants and helpers for the joint planner and its
// iterative arithmetic unit.
// ----------------------------------------------------------------------------
package stjp_pkg;

   localparam int JOINTS_DEF = 6;

   localparam int WORK_W    = 80;
   localparam int OPB_W     = 40;
   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W = 34;
   localparam int TIME_W    = 40;

   localparam logic [16:0]       FULL_RATIO = 17'h10000;
   localparam logic [TIME_W-1:0] MAX_TIME   = {TIME_W{1'b1}};
   localparam logic [TIME_W-1:0] HOLD_TIME  = TIME_W'(64'd99999 << 16);

   localparam logic [6:0] DIV_STEPS  = 7'd64;
   localparam logic [6:0] ROOT_STEPS = 7'd40;

   typedef enum logic [1:0] {
      OP_DIV  = 2'd0,
      OP_SQRT = 2'd1,
      OP_MUL  = 2'd2
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

   function automatic logic [TIME_W-1:0] sat_time(input logic [63:0] value);
      logic [TIME_W-1:0] res;
      res = (value > 64'(MAX_TIME)) ? MAX_TIME : value[TIME_W-1:0];
      return res;
   endfunction

endpackage

// File: sv/stjp_arith.sv
// ----------------------------------------------------------------------------
// Iterative arithmetic unit
// One bit per cycle: restoring divide (64 by 34 bits), digit square root
// (80-bit radicand) and shift-add multiply (40 by 40 bits).
// ----------------------------------------------------------------------------
module stjp_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  stjp_pkg::arith_req_type       req,
   input  logic [stjp_pkg::WORK_W-1:0]   operand_a,
   input  logic [stjp_pkg::OPB_W-1:0]    operand_b,
   output stjp_pkg::arith_stat_type      stat,
   output logic [stjp_pkg::WORK_W-1:0]   result
);

   stjp_pkg::arith_op_type op_ff, op_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [6:0]             cnt_ff, cnt_in;
   logic [79:0]            work_ff, work_in;
   logic [41:0]            rem_ff, rem_in;
   logic [39:0]            root_ff, root_in;
   logic [39:0]            opb_ff, opb_in;

   logic [34:0] div_sh;
   logic [35:0] div_diff;
   logic [43:0] sq_sh;
   logic [43:0] sq_trial;
   logic [44:0] sq_diff;
   logic [40:0] mul_sum;

   always_comb begin
      div_sh   = {rem_ff[33:0], work_ff[63]};
      div_diff = {1'b0, div_sh} - {2'b00, opb_ff[33:0]};
      sq_sh    = {rem_ff, work_ff[79:78]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_diff  = {1'b0, sq_sh} - {1'b0, sq_trial};
      mul_sum  = {1'b0, work_ff[79:40]} + {1'b0, (work_ff[0] ? opb_ff : 40'd0)};

      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      opb_in  = opb_ff;

      if (req.start) begin
         op_in   = req.op;
         busy_in = 1'b1;
         work_in = operand_a;
         rem_in  = '0;
         root_in = '0;
         opb_in  = operand_b;
         cnt_in  = (req.op == stjp_pkg::OP_DIV) ? stjp_pkg::DIV_STEPS : stjp_pkg::ROOT_STEPS;
      end else if (busy_ff) begin
         case (op_ff)
            stjp_pkg::OP_DIV: begin
               rem_in  = {8'd0, (div_diff[35] ? div_sh[33:0] : div_diff[33:0])};
               work_in = {work_ff[79:64], work_ff[62:0], ~div_diff[35]};
            end
            stjp_pkg::OP_SQRT: begin
               rem_in  = sq_diff[44] ? sq_sh[41:0] : sq_diff[41:0];
               root_in = {root_ff[38:0], ~sq_diff[44]};
               work_in = {work_ff[77:0], 2'b00};
            end
            stjp_pkg::OP_MUL: begin
               work_in = {mul_sum, work_ff[39:1]};
            end
            default: begin
               work_in = work_ff;
            end
         endcase
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= stjp_pkg::OP_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      opb_ff  <= opb_in;
   end

   always_comb begin
      case (op_ff)
         stjp_pkg::OP_DIV:  result = {16'd0, work_ff[63:0]};
         stjp_pkg::OP_SQRT: result = {40'd0, root_ff};
         default:           result = work_ff;
      endcase
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: sv/synced_trapezoid_joint_planner.sv
// ----------------------------------------------------------------------------
// Synchronized trapezoid joint planner
// Collects one word per joint and plans trapezoidal moves that end together.
//
//   channel  direction  handshake            contents
//   req      in         tvalid/tready        joint limits and targets, tlast
//   rsp      out        tvalid/tready        phase times and acceleration
//   csr      in         psel/penable/pready  mode, ratios, step size
//
// A joint word is captured in IDLE and stored in LOAD. The last word then runs the
// shared divide/root/multiply unit, one bit per cycle, for the minimum time of
// every joint, and once more for each joint that is slowed down.
// Synchronous reset clears the control state. The request side is held off
// while a plan runs; a full result register stalls the plan, not the input.
// ----------------------------------------------------------------------------
module synced_trapezoid_joint_planner #(
   parameter int JOINTS = stjp_pkg::JOINTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_angle, target_angle, jog_direction, max_speed, max_accel,
   // lower_limit, upper_limit
   input  logic [191:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // joint_index, accel_end_time, cruise_end_time, total_time, accel_value
   output logic [159:0] rsp_tdata,
   // status
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int CW = $clog2(JOINTS + 1);
   localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   typedef enum logic [1:0] {
      REG_PLAN_MODE   = 2'd0,
      REG_SPEED_RATIO = 2'd1,
      REG_ACCEL_RATIO = 2'd2,
      REG_STEP_ANGLE  = 2'd3
   } csr_reg_type;

   localparam logic [1:0] MODE_STEP = 2'd0;
   localparam logic [1:0] MODE_CONT = 2'd1;
   localparam logic [1:0] SIGN_NONE = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd2;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_LOAD   = 14'b00000000000010,
      ST_RATIO  = 14'b00000000000100,
      ST_CRUISE = 14'b00000000001000,
      ST_TRIP   = 14'b00000000010000,
      ST_QUOT   = 14'b00000000100000,
      ST_ROOT   = 14'b00000001000000,
      ST_NEXT   = 14'b00000010000000,
      ST_SEL    = 14'b00000100000000,
      ST_REQ    = 14'b00001000000000,
      ST_SQR    = 14'b00010000000000,
      ST_REPLAN = 14'b00100000000000,
      ST_EMIT   = 14'b01000000000000,
      ST_FAULT  = 14'b10000000000000
   } state_type;

   // Configuration registers.
   logic [1:0]  plan_mode_ff;
   logic [16:0] speed_ratio_ff;
   logic [16:0] accel_ratio_ff;
   logic [30:0] step_angle_ff;
   logic        csr_write;
   csr_reg_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_mode_ff   <= MODE_STEP;
         speed_ratio_ff <= stjp_pkg::FULL_RATIO;
         accel_ratio_ff <= stjp_pkg::FULL_RATIO;
         step_angle_ff  <= 31'd10486;
      end else if (csr_write) begin
         case (csr_index)
            REG_PLAN_MODE:   plan_mode_ff   <= csr_pwdata[1:0];
            REG_SPEED_RATIO: speed_ratio_ff <= csr_pwdata[16:0];
            REG_ACCEL_RATIO: accel_ratio_ff <= csr_pwdata[16:0];
            REG_STEP_ANGLE:  step_angle_ff  <= csr_pwdata[30:0];
            default:         plan_mode_ff   <= plan_mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PLAN_MODE:   csr_prdata = {30'd0, plan_mode_ff};
         REG_SPEED_RATIO: csr_prdata = {15'd0, speed_ratio_ff};
         REG_ACCEL_RATIO: csr_prdata = {15'd0, accel_ratio_ff};
         REG_STEP_ANGLE:  csr_prdata = {1'b0, step_angle_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Sequencer state.
   state_type     state_ff, state_in;
   logic          start_ff, start_in;
   logic [CW-1:0] loaded_ff, loaded_in;
   logic          fault_ff, fault_in;
   logic [CW-1:0] n_ff, n_in;
   logic          cont_ff, cont_in;
   logic [IW-1:0] joint_ff, joint_in;
   logic [39:0]   dur_ff, dur_in;
   logic [46:0]   ratio_raw_ff, ratio_raw_in;
   logic [63:0]   q_ff, q_in;
   logic [39:0]   t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [191:0]  word_ff, word_in;
   logic          word_last_ff, word_last_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [159:0]  rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in;
   logic          rsp_last_ff, rsp_last_in;

   // Per-joint stores.
   logic [31:0] trip_ff  [JOINTS];
   logic [30:0] speed_ff [JOINTS];
   logic [33:0] accel_ff [JOINTS];
   logic [1:0]  sign_ff  [JOINTS];
   logic [39:0] ratio_ff [JOINTS];
   logic        cruise_ff[JOINTS];
   logic [39:0] tmin_ff  [JOINTS];

   logic        store_we, ratio_we, cruise_we, tmin_we;
   logic [31:0] trip_in;
   logic [30:0] speed_in;
   logic [33:0] accel_in;
   logic [1:0]  sign_in;
   logic [39:0] ratio_in, tmin_in;
   logic        cruise_in;

   // Unit interface.
   stjp_pkg::arith_req_type  arith_req;
   stjp_pkg::arith_stat_type arith_stat;
   stjp_pkg::arith_op_type   arith_op;
   logic [79:0]              arith_a, arith_res;
   logic [39:0]              arith_b;

   // Word fields.
   logic signed [32:0] start_ext, target_ext, lower_ext, upper_ext, step_ext, chk, diff;
   logic [1:0]         dir;
   logic [30:0]        max_speed, max_accel;
   logic [16:0]        sr, ar;
   logic [47:0]        w_prod;
   logic [32:0]        ma3;
   logic [49:0]        a_prod;
   logic [30:0]        w_val;
   logic [33:0]        a_val;
   logic               check_en, item_fault, room;

   // Current joint.
   logic [31:0] cur_trip;
   logic [30:0] cur_speed;
   logic [33:0] cur_accel;
   logic [1:0]  cur_sign;
   logic [39:0] cur_ratio, cur_tmin;
   logic        cur_cruise;
   logic        last_j, out_free;
   logic [61:0] w_sq;
   logic [48:0] tmin_sum;
   logic [80:0] rad_diff;
   logic [39:0] root_r;
   logic [40:0] dur_plus;
   logic [34:0] acc_out;

   assign start_ext  = {word_ff[31], word_ff[31:0]};
   assign target_ext = {word_ff[63], word_ff[63:32]};
   assign lower_ext  = {word_ff[159], word_ff[159:128]};
   assign upper_ext  = {word_ff[191], word_ff[191:160]};
   assign step_ext   = {2'b00, step_angle_ff};
   assign dir        = word_ff[65:64];
   assign max_speed  = word_ff[96:66];
   assign max_accel  = word_ff[127:97];

   always_comb begin
      sr     = (speed_ratio_ff > stjp_pkg::FULL_RATIO) ? stjp_pkg::FULL_RATIO : speed_ratio_ff;
      ar     = (accel_ratio_ff > stjp_pkg::FULL_RATIO) ? stjp_pkg::FULL_RATIO : accel_ratio_ff;
      w_prod = 48'(max_speed) * 48'(sr);
      ma3    = 33'({max_accel, 1'b0}) + 33'(max_accel);
      a_prod = 50'(ma3) * 50'(ar);
      w_val  = (w_prod[46:16] == 31'd0) ? 31'd1 : w_prod[46:16];
      a_val  = (a_prod[49:16] == 34'd0) ? 34'd1 : a_prod[49:16];

      sign_in  = (dir == SIGN_POS) ? SIGN_POS : (dir == SIGN_NEG) ? SIGN_NEG : SIGN_NONE;
      trip_in  = '0;
      chk      = '0;
      check_en = 1'b1;
      diff     = target_ext - start_ext;
      if (plan_mode_ff == MODE_CONT) begin
         check_en = 1'b0;
      end else if (plan_mode_ff == MODE_STEP) begin
         chk = (sign_in == SIGN_POS) ? start_ext + step_ext :
               (sign_in == SIGN_NEG) ? start_ext - step_ext : start_ext;
         trip_in = (sign_in == SIGN_NONE) ? 32'd0 : {1'b0, step_angle_ff};
      end else begin
         chk     = target_ext;
         sign_in = (diff > 0) ? SIGN_POS : (diff < 0) ? SIGN_NEG : SIGN_NONE;
         trip_in = diff[32] ? 32'(-diff) : diff[31:0];
      end
      item_fault = check_en && ((chk < lower_ext) || (chk > upper_ext));
      speed_in   = w_val;
      accel_in   = a_val;
      room       = (loaded_ff < CW'(JOINTS));
   end

   assign cur_trip   = trip_ff[joint_ff];
   assign cur_speed  = speed_ff[joint_ff];
   assign cur_accel  = accel_ff[joint_ff];
   assign cur_sign   = sign_ff[joint_ff];
   assign cur_ratio  = ratio_ff[joint_ff];
   assign cur_tmin   = tmin_ff[joint_ff];
   assign cur_cruise = cruise_ff[joint_ff];
   assign last_j     = ((CW'(joint_ff) + CW'(1)) == n_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign w_sq       = 62'(cur_speed) * 62'(cur_speed);

   // Operands follow the state that the start pulse belongs to.
   always_comb begin
      arith_op = stjp_pkg::OP_DIV;
      arith_a  = '0;
      arith_b  = 40'(cur_accel);
      rad_diff = {1'b0, arith_res} - {15'd0, q_ff, 2'b00};
      case (state_ff)
         ST_RATIO:  arith_a = 80'({cur_speed, 16'd0});
         ST_CRUISE: arith_a = 80'(w_sq);
         ST_TRIP: begin
            arith_a = 80'({cur_trip, 16'd0});
            arith_b = 40'(cur_speed);
         end
         ST_QUOT, ST_REQ: arith_a = 80'({cur_trip, 32'd0});
         ST_ROOT: begin
            arith_op = stjp_pkg::OP_SQRT;
            arith_a  = arith_res;
         end
         ST_SQR: begin
            arith_op = stjp_pkg::OP_MUL;
            arith_a  = 80'(dur_ff);
            arith_b  = dur_ff;
         end
         ST_REPLAN: begin
            arith_op = stjp_pkg::OP_SQRT;
            arith_a  = rad_diff[80] ? 80'd0 : rad_diff[79:0];
         end
         default: arith_a = '0;
      endcase
   end

   assign arith_req.start = start_ff;
   assign arith_req.op    = arith_op;

   stjp_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .req       (arith_req),
      .operand_a (arith_a),
      .operand_b (arith_b),
      .stat      (arith_stat),
      .result    (arith_res)
   );

   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      loaded_in    = loaded_ff;
      fault_in     = fault_ff;
      n_in         = n_ff;
      cont_in      = cont_ff;
      joint_in     = joint_ff;
      dur_in       = dur_ff;
      ratio_raw_in = ratio_raw_ff;
      q_in         = q_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      t3_in        = t3_ff;
      word_in      = word_ff;
      word_last_in = word_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      store_we     = 1'b0;
      ratio_we     = 1'b0;
      cruise_we    = 1'b0;
      tmin_we      = 1'b0;
      ratio_in     = stjp_pkg::sat_time(64'(arith_res[46:0]));
      cruise_in    = (64'(cur_trip) > arith_res[63:0]);
      tmin_sum     = 49'(ratio_raw_ff) + 49'(arith_res[47:0]);
      tmin_in      = stjp_pkg::sat_time(64'(tmin_sum));
      root_r       = (arith_res[39:0] > dur_ff) ? dur_ff : arith_res[39:0];
      dur_plus     = {1'b0, dur_ff} + {1'b0, root_r};
      acc_out      = (cur_sign == SIGN_POS) ? {1'b0, cur_accel} :
                     (cur_sign == SIGN_NEG) ? 35'd0 - {1'b0, cur_accel} : 35'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in      = req_tdata;
               word_last_in = req_tlast;
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (room) begin
               store_we  = 1'b1;
               loaded_in = loaded_ff + CW'(1);
               fault_in  = fault_ff | item_fault;
            end
            state_in = ST_IDLE;
            if (word_last_ff) begin
               n_in      = loaded_in;
               loaded_in = '0;
               cont_in   = (plan_mode_ff == MODE_CONT);
               joint_in  = '0;
               dur_in    = '0;
               if (fault_in) begin
                  fault_in = 1'b0;
                  state_in = ST_FAULT;
               end else if (n_in != '0) begin
                  state_in = ST_RATIO;
                  start_in = 1'b1;
               end
            end
         end
         ST_RATIO: begin
            if (arith_stat.done) begin
               ratio_raw_in = arith_res[46:0];
               ratio_we     = 1'b1;
               state_in     = ST_CRUISE;
               start_in     = 1'b1;
            end
         end
         ST_CRUISE: begin
            if (arith_stat.done) begin
               cruise_we = 1'b1;
               state_in  = cruise_in ? ST_TRIP : ST_QUOT;
               start_in  = 1'b1;
            end
         end
         ST_TRIP: begin
            if (arith_stat.done) begin
               tmin_we  = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_QUOT: begin
            if (arith_stat.done) begin
               state_in = ST_ROOT;
               start_in = 1'b1;
            end
         end
         ST_ROOT: begin
            if (arith_stat.done) begin
               tmin_in  = {7'd0, arith_res[31:0], 1'b0};
               tmin_we  = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (cur_tmin > dur_ff) begin
               dur_in = cur_tmin;
            end
            if (last_j) begin
               joint_in = '0;
               state_in = ST_SEL;
            end else begin
               joint_in = joint_ff + IW'(1);
               state_in = ST_RATIO;
               start_in = 1'b1;
            end
         end
         ST_SEL: begin
            state_in = ST_EMIT;
            if (cont_ff) begin
               t3_in = stjp_pkg::HOLD_TIME;
               if (cur_sign == SIGN_NONE) begin
                  t1_in = '0;
                  t2_in = stjp_pkg::HOLD_TIME;
               end else begin
                  t1_in = cur_ratio;
                  t2_in = (stjp_pkg::HOLD_TIME > cur_ratio) ?
                          stjp_pkg::HOLD_TIME - cur_ratio : 40'd0;
               end
            end else if (cur_sign == SIGN_NONE) begin
               t1_in = '0;
               t2_in = dur_ff;
               t3_in = dur_ff;
            end else if (dur_ff <= cur_tmin) begin
               t3_in = dur_ff;
               if (cur_cruise) begin
                  t1_in = cur_ratio;
                  t2_in = (dur_ff > cur_ratio) ? dur_ff - cur_ratio : 40'd0;
               end else begin
                  t1_in = dur_ff >> 1;
                  t2_in = dur_ff >> 1;
               end
            end else begin
               state_in = ST_REQ;
               start_in = 1'b1;
            end
         end
         ST_REQ: begin
            if (arith_stat.done) begin
               q_in     = arith_res[63:0];
               state_in = ST_SQR;
               start_in = 1'b1;
            end
         end
         ST_SQR: begin
            if (arith_stat.done) begin
               state_in = ST_REPLAN;
               start_in = 1'b1;
            end
         end
         ST_REPLAN: begin
            if (arith_stat.done) begin
               t1_in    = (dur_ff - root_r) >> 1;
               t2_in    = dur_plus[40:1];
               t3_in    = dur_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, acc_out, t3_ff, t2_ff, t1_ff, 3'(joint_ff)};
               rsp_user_in  = 1'b0;
               rsp_last_in  = last_j;
               if (last_j) begin
                  state_in = ST_IDLE;
               end else begin
                  joint_in = joint_ff + IW'(1);
                  state_in = ST_SEL;
               end
            end
         end
         ST_FAULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         loaded_ff    <= '0;
         fault_ff     <= 1'b0;
         n_ff         <= '0;
         cont_ff      <= 1'b0;
         joint_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         loaded_ff    <= loaded_in;
         fault_ff     <= fault_in;
         n_ff         <= n_in;
         cont_ff      <= cont_in;
         joint_ff     <= joint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dur_ff       <= dur_in;
      ratio_raw_ff <= ratio_raw_in;
      q_ff         <= q_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      t3_ff        <= t3_in;
      word_ff      <= word_in;
      word_last_ff <= word_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         trip_ff[loaded_ff[IW-1:0]]  <= trip_in;
         speed_ff[loaded_ff[IW-1:0]] <= speed_in;
         accel_ff[loaded_ff[IW-1:0]] <= accel_in;
         sign_ff[loaded_ff[IW-1:0]]  <= sign_in;
      end
      if (ratio_we) begin
         ratio_ff[joint_ff] <= ratio_in;
      end
      if (cruise_we) begin
         cruise_ff[joint_ff] <= cruise_in;
      end
      if (tmin_we) begin
         tmin_ff[joint_ff] <= tmin_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_fault_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[2:0] == 3'd0))
      else $error("fault word is not a lone final word");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> !arith_stat.busy)
      else $error("arithmetic unit started while busy");

   a_loaded_range: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CW'(JOINTS))
      else $error("joint count beyond store depth");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (CW'(joint_ff) < n_ff))
      else $error("emitted joint beyond plan size");

endmodule
